FILE: hdl/scd_pkg.sv
// Shared package for the segment and circle hit test with damage.
// Holds field widths, the default coordinate width and the item tags that travel
// down the pipeline. It depends on nothing.
package scd_pkg;

	localparam int SCD_COORD_BITS = 16;
	localparam int RADIUS_BITS    = 15;
	localparam int HEALTH_BITS    = 16;
	localparam int DAMAGE_BITS    = 16;

	typedef struct packed {
		logic                   valid;
		logic [HEALTH_BITS-1:0] health;
	} scd_tag_t;

	typedef struct packed {
		logic                   valid;
		logic                   early_hit;
		logic                   need_wide;
		logic [HEALTH_BITS-1:0] health;
	} scd_cls_t;

	function automatic int scd_sum_bits(input int coord_bits);
		return (2 * coord_bits + 4 > 32) ? 2 * coord_bits + 4 : 32;
	endfunction

endpackage

FILE: hdl/scd_geom.sv
// Front three pipeline stages: coordinate differences, squares and dot products,
// and the sums that form the quadratic coefficients and end values.
// Depends on scd_pkg.
module scd_geom #(
	parameter int COORD_BITS = scd_pkg::SCD_COORD_BITS,
	localparam int SW = scd_pkg::scd_sum_bits(COORD_BITS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	input  logic signed [COORD_BITS-1:0]        circle_x,
	input  logic signed [COORD_BITS-1:0]        circle_y,
	input  logic [scd_pkg::RADIUS_BITS-1:0]     radius,
	input  logic [scd_pkg::HEALTH_BITS-1:0]     health_in,
	output scd_pkg::scd_tag_t                   tag_s3,
	output logic signed [SW-1:0]                a_s3,
	output logic signed [SW-1:0]                h_s3,
	output logic signed [SW-1:0]                f0_s3,
	output logic signed [SW-1:0]                f1_s3
);
	import scd_pkg::*;

	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * DW;
	localparam int R2W = 2 * RADIUS_BITS;

	logic signed [DW-1:0] sx_e, sy_e, ex_e, ey_e, cx_e, cy_e;
	logic signed [DW-1:0] dx_s1, dy_s1, fx_s1, fy_s1, gx_s1, gy_s1;
	logic [RADIUS_BITS-1:0] r_s1;
	scd_tag_t tag_s1, tag_s2;

	logic signed [PW-1:0] dxx_s2, dyy_s2, fdx_s2, fdy_s2, fxx_s2, fyy_s2, gxx_s2, gyy_s2;
	logic [R2W-1:0] r2_s2;

	assign sx_e = {start_x[COORD_BITS-1], start_x};
	assign sy_e = {start_y[COORD_BITS-1], start_y};
	assign ex_e = {end_x[COORD_BITS-1], end_x};
	assign ey_e = {end_y[COORD_BITS-1], end_y};
	assign cx_e = {circle_x[COORD_BITS-1], circle_x};
	assign cy_e = {circle_y[COORD_BITS-1], circle_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= '{valid: in_valid, health: health_in};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= ex_e - sx_e;
		dy_s1 <= ey_e - sy_e;
		fx_s1 <= sx_e - cx_e;
		fy_s1 <= sy_e - cy_e;
		gx_s1 <= ex_e - cx_e;
		gy_s1 <= ey_e - cy_e;
		r_s1  <= radius;

		dxx_s2 <= dx_s1 * dx_s1;
		dyy_s2 <= dy_s1 * dy_s1;
		fdx_s2 <= fx_s1 * dx_s1;
		fdy_s2 <= fy_s1 * dy_s1;
		fxx_s2 <= fx_s1 * fx_s1;
		fyy_s2 <= fy_s1 * fy_s1;
		gxx_s2 <= gx_s1 * gx_s1;
		gyy_s2 <= gy_s1 * gy_s1;
		r2_s2  <= r_s1 * r_s1;

		a_s3  <= SW'(dxx_s2) + SW'(dyy_s2);
		h_s3  <= SW'(fdx_s2) + SW'(fdy_s2);
		f0_s3 <= SW'(fxx_s2) + SW'(fyy_s2) - $signed(SW'(r2_s2));
		f1_s3 <= SW'(gxx_s2) + SW'(gyy_s2) - $signed(SW'(r2_s2));
	end

endmodule

FILE: hdl/scd_classify.sv
// Fourth pipeline stage: settles the easy cases from the end values and flags the
// items that need the wide comparison of the squared projection against a times f0.
// Depends on scd_pkg.
module scd_classify #(
	parameter int COORD_BITS = scd_pkg::SCD_COORD_BITS,
	localparam int SW = scd_pkg::scd_sum_bits(COORD_BITS),
	localparam int AW = 2 * COORD_BITS + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scd_pkg::scd_tag_t     tag_s3,
	input  logic signed [SW-1:0]  a_s3,
	input  logic signed [SW-1:0]  h_s3,
	input  logic signed [SW-1:0]  f0_s3,
	input  logic signed [SW-1:0]  f1_s3,
	output scd_pkg::scd_cls_t     cls_s4,
	output logic [AW-1:0]         negh_s4,
	output logic [AW-1:0]         a_s4,
	output logic [AW-1:0]         f0_s4
);
	import scd_pkg::*;

	logic signed [SW-1:0] negh;
	logic a_zero, end_zero, differ, f0_neg, in_range;
	logic early_hit, need_wide;

	always_comb begin
		negh      = -h_s3;
		a_zero    = (a_s3 == '0);
		end_zero  = (f0_s3 == '0) || (f1_s3 == '0);
		differ    = f0_s3[SW-1] ^ f1_s3[SW-1];
		f0_neg    = f0_s3[SW-1];
		in_range  = h_s3[SW-1] && (negh < a_s3);
		early_hit = !a_zero && (end_zero || differ);
		need_wide = !a_zero && !end_zero && !differ && !f0_neg && in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_s4 <= '0;
		end else begin
			cls_s4 <= '{valid: tag_s3.valid, early_hit: early_hit,
				need_wide: need_wide, health: tag_s3.health};
		end
	end

	always_ff @(posedge clk) begin
		negh_s4 <= negh[AW-1:0];
		a_s4    <= a_s3[AW-1:0];
		f0_s4   <= f0_s3[AW-1:0];
	end

endmodule

FILE: hdl/scd_wide_cmp.sv
// Stages five to seven: split products of the squared projection and of a times f0,
// their assembly into full width, and the final comparison.
// Depends on scd_pkg.
module scd_wide_cmp #(
	parameter int COORD_BITS = scd_pkg::SCD_COORD_BITS,
	localparam int AW = 2 * COORD_BITS + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scd_pkg::scd_cls_t cls_s4,
	input  logic [AW-1:0]     negh_s4,
	input  logic [AW-1:0]     a_s4,
	input  logic [AW-1:0]     f0_s4,
	output scd_pkg::scd_cls_t cls_s7,
	output logic              ge_s7
);
	import scd_pkg::*;

	localparam int LW  = (AW + 1) / 2;
	localparam int HW  = AW - LW;
	localparam int PFW = 2 * AW;

	scd_cls_t cls_s5, cls_s6;

	logic [2*LW-1:0]    pll_s5, qll_s5;
	logic [LW+HW-1:0]   plh_s5, qlh_s5, qhl_s5;
	logic [2*HW-1:0]    phh_s5, qhh_s5;
	logic [PFW-1:0]     p_s6, q_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_s5 <= '0;
			cls_s6 <= '0;
			cls_s7 <= '0;
		end else begin
			cls_s5 <= cls_s4;
			cls_s6 <= cls_s5;
			cls_s7 <= cls_s6;
		end
	end

	always_ff @(posedge clk) begin
		pll_s5 <= negh_s4[LW-1:0] * negh_s4[LW-1:0];
		plh_s5 <= negh_s4[LW-1:0] * negh_s4[AW-1:LW];
		phh_s5 <= negh_s4[AW-1:LW] * negh_s4[AW-1:LW];
		qll_s5 <= a_s4[LW-1:0] * f0_s4[LW-1:0];
		qlh_s5 <= a_s4[LW-1:0] * f0_s4[AW-1:LW];
		qhl_s5 <= a_s4[AW-1:LW] * f0_s4[LW-1:0];
		qhh_s5 <= a_s4[AW-1:LW] * f0_s4[AW-1:LW];

		p_s6 <= (PFW'(phh_s5) << (2 * LW)) + (PFW'(plh_s5) << (LW + 1)) + PFW'(pll_s5);
		q_s6 <= (PFW'(qhh_s5) << (2 * LW)) + (PFW'(qlh_s5) << LW)
			+ (PFW'(qhl_s5) << LW) + PFW'(qll_s5);

		ge_s7 <= (p_s6 >= q_s6);
	end

endmodule

FILE: hdl/segment_circle_hit_damage.sv
// Top level of the segment and circle hit test with damage.
// Instantiates scd_geom, scd_classify and scd_wide_cmp; depends on scd_pkg.
//
// The block takes one item per clock cycle and never asserts busy. Each item's
// result appears on done, hit and health_out for one cycle, once it has passed through
// the eight register stages of the pipeline
// (differences, products, sums, classification, split wide products, their
// assembly, the wide compare, and the damage update). Results cannot be held off,
// so a consumer must take every done cycle. Write damage_amount only while no item
// is in flight.
module segment_circle_hit_damage #(
	parameter int COORD_BITS = scd_pkg::SCD_COORD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COORD_BITS-1:0]     start_x,
	input  logic signed [COORD_BITS-1:0]     start_y,
	input  logic signed [COORD_BITS-1:0]     end_x,
	input  logic signed [COORD_BITS-1:0]     end_y,
	input  logic signed [COORD_BITS-1:0]     circle_x,
	input  logic signed [COORD_BITS-1:0]     circle_y,
	input  logic [scd_pkg::RADIUS_BITS-1:0]  radius,
	input  logic [scd_pkg::HEALTH_BITS-1:0]  health_in,
	input  logic                             cfg_wr_en,
	input  logic [scd_pkg::DAMAGE_BITS-1:0]  cfg_wr_data,
	output logic                             done,
	output logic                             hit,
	output logic [scd_pkg::HEALTH_BITS-1:0]  health_out
);
	import scd_pkg::*;

	localparam int SW = scd_sum_bits(COORD_BITS);
	localparam int AW = 2 * COORD_BITS + 2;

	logic [DAMAGE_BITS-1:0] damage_amount_q;

	scd_tag_t tag_s3;
	scd_cls_t cls_s4, cls_s7;
	logic signed [SW-1:0] a_s3, h_s3, f0_s3, f1_s3;
	logic [AW-1:0] negh_s4, a_s4, f0_s4;
	logic ge_s7;

	logic valid_s8, hit_s8;
	logic [HEALTH_BITS-1:0] health_s8;
	logic hit_now;
	logic [HEALTH_BITS-1:0] health_now;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damage_amount_q <= '0;
		end else if (cfg_wr_en) begin
			damage_amount_q <= cfg_wr_data;
		end
	end

	scd_geom #(.COORD_BITS(COORD_BITS)) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.circle_x  (circle_x),
		.circle_y  (circle_y),
		.radius    (radius),
		.health_in (health_in),
		.tag_s3    (tag_s3),
		.a_s3      (a_s3),
		.h_s3      (h_s3),
		.f0_s3     (f0_s3),
		.f1_s3     (f1_s3)
	);

	scd_classify #(.COORD_BITS(COORD_BITS)) u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s3  (tag_s3),
		.a_s3    (a_s3),
		.h_s3    (h_s3),
		.f0_s3   (f0_s3),
		.f1_s3   (f1_s3),
		.cls_s4  (cls_s4),
		.negh_s4 (negh_s4),
		.a_s4    (a_s4),
		.f0_s4   (f0_s4)
	);

	scd_wide_cmp #(.COORD_BITS(COORD_BITS)) u_wide_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cls_s4  (cls_s4),
		.negh_s4 (negh_s4),
		.a_s4    (a_s4),
		.f0_s4   (f0_s4),
		.cls_s7  (cls_s7),
		.ge_s7   (ge_s7)
	);

	always_comb begin
		hit_now = cls_s7.early_hit || (cls_s7.need_wide && ge_s7);
		if (!hit_now) begin
			health_now = cls_s7.health;
		end else if (cls_s7.health > damage_amount_q) begin
			health_now = cls_s7.health - damage_amount_q;
		end else begin
			health_now = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= cls_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_s8    <= hit_now;
		health_s8 <= health_now;
	end

	assign done       = valid_s8;
	assign hit        = hit_s8;
	assign health_out = health_s8;

	// Every accepted item produces its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##8 done)
		else $error("accepted item produced no result after eight cycles");

	// A miss leaves health untouched.
	a_miss_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> health_out == $past(health_in, 8))
		else $error("health changed on a miss");

	// A hit never raises health.
	a_hit_le: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> health_out <= $past(health_in, 8))
		else $error("health rose on a hit");

endmodule
